// File: rtl/dedup_store_forward_frame_buffer_core_defines.svh
// Assertion macros shared by the frame buffer RTL.
`ifndef DEDUP_STORE_FORWARD_FRAME_BUFFER_CORE_DEFINES_SVH
`define DEDUP_STORE_FORWARD_FRAME_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk outside of reset.
`define DSFB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside of reset.
`define DSFB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dsfb_pkg.sv
// Shared types and codes of the frame buffer.
package dsfb_pkg;

  // Default number of descriptor slots.
  localparam int DEPTH_DEF = 16;

  // Request codes.
  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Result codes.
  localparam logic [1:0] KIND_STORED    = 2'd0;
  localparam logic [1:0] KIND_DUPLICATE = 2'd1;
  localparam logic [1:0] KIND_DELIVERED = 2'd2;
  localparam logic [1:0] KIND_NONE      = 2'd3;

  // One frame descriptor as held in a slot.
  typedef struct packed {
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] handle;
    logic [11:0] length;
  } slot_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/dsfb_slot_ram.sv
// Descriptor slot memory: one write port, one registered read port.
module dsfb_slot_ram
  import dsfb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  slot_t                                  wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output slot_t                                  rd_data
);

  slot_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/dedup_store_forward_frame_buffer_core.sv
// Top level of the deduplicating store-and-forward frame buffer.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_ready  | req_type src_addr dest_addr frame_handle
//           |                      | payload_length
//   out     | out_valid / out_ready| result_kind out_src out_dest out_handle
//           |                      | out_length last_of_run
//
// The slot memory is walked from oldest to youngest, one slot read per cycle
// while the output does not stall the walk, and then the finish state ends the item.
// A store that hits a duplicate ends as soon as the matching slot is read.
// Reset clears the control state, the occupancy and the ring head; slots are never cleared.
// A stalled output holds the walk whenever a second match needs the output.
`include "dedup_store_forward_frame_buffer_core_defines.svh"

module dedup_store_forward_frame_buffer_core
  import dsfb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  src_addr,
  input  logic [7:0]  dest_addr,
  input  logic [15:0] frame_handle,
  input  logic [11:0] payload_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  out_src,
  output logic [7:0]  out_dest,
  output logic [15:0] out_handle,
  output logic [11:0] out_length,
  output logic        last_of_run
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Ring position of the slot that lies ofs entries after base.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(ofs);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] occupancy;
  logic [AW-1:0] head;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] keep;
  logic          pend;
  logic          held_v;
  logic          dup;
  logic          req_q;
  slot_t         key;
  slot_t         held;
  slot_t         out_slot;
  logic [1:0]    out_kind;
  logic          out_last;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  slot_t         rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;

  logic          out_load;
  logic [1:0]    load_kind;
  slot_t         load_slot;
  logic          load_last;

  logic          out_free;
  logic          s_hit;
  logic          d_hit;
  logic          stall;
  logic          adv;
  logic          scan_more;

  // Slot memory.
  dsfb_slot_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Match and flow conditions of the slot that was read last.
  assign out_free  = !out_valid || out_ready;
  assign s_hit     = pend && (rd_data.src == key.src) && (rd_data.dst == key.dst);
  assign d_hit     = pend && (rd_data.dst == key.dst);
  assign stall     = (req_q == REQ_FETCH) && d_hit && held_v && !out_free;
  assign adv       = (state == ST_SCAN) && !stall;
  assign scan_more = (rd_cnt != occupancy);
  assign in_ready  = (state == ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv && (req_q == REQ_STORE) && s_hit) begin
          state_next = ST_FINISH;
        end else if (adv && !scan_more) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory accesses and output loads.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = wrap_add(head, rd_cnt);
    wr_en     = 1'b0;
    wr_addr   = wrap_add(head, keep);
    wr_data   = rd_data;
    out_load  = 1'b0;
    load_kind = KIND_DELIVERED;
    load_slot = held;
    load_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        rd_en = adv && scan_more;
        // Kept slots move down behind the deliveries to close the gaps.
        if (adv && (req_q == REQ_FETCH) && pend && !d_hit) begin
          wr_en = 1'b1;
        end
        // A new match pushes the one held before it; that one is not last.
        if (adv && (req_q == REQ_FETCH) && d_hit && held_v) begin
          out_load = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_last = 1'b1;
          if (req_q == REQ_STORE) begin
            load_kind = dup ? KIND_DUPLICATE : KIND_STORED;
            load_slot = key;
            if (!dup) begin
              wr_en   = 1'b1;
              wr_addr = (occupancy == DEPTH_C) ? head : wrap_add(head, occupancy);
              wr_data = key;
            end
          end else if (held_v) begin
            load_kind = KIND_DELIVERED;
            load_slot = held;
          end else begin
            load_kind = KIND_NONE;
            load_slot = '{src: 8'd0, dst: key.dst, handle: 16'd0, length: 12'd0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occupancy <= '0;
      head      <= '0;
      pend      <= 1'b0;
      held_v    <= 1'b0;
      dup       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          pend   <= 1'b0;
          held_v <= 1'b0;
          dup    <= 1'b0;
        end
        ST_SCAN: begin
          if (adv) begin
            pend <= scan_more;
            if ((req_q == REQ_FETCH) && d_hit) begin
              held_v <= 1'b1;
            end
            if ((req_q == REQ_STORE) && s_hit) begin
              dup <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (req_q == REQ_STORE) begin
              if (!dup) begin
                if (occupancy == DEPTH_C) begin
                  head <= wrap_add(head, CW'(1));
                end else begin
                  occupancy <= occupancy + CW'(1);
                end
              end
            end else begin
              occupancy <= keep;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Walk counters, item key, held match and output payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      keep   <= '0;
    end else if (in_valid && in_ready) begin
      rd_cnt <= '0;
      keep   <= '0;
    end else if (adv) begin
      if (scan_more) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      if ((req_q == REQ_FETCH) && pend && !d_hit) begin
        keep <= keep + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q <= req_type;
      key   <= '{src: src_addr, dst: dest_addr, handle: frame_handle,
                 length: payload_length};
    end
    if (adv && (req_q == REQ_FETCH) && d_hit) begin
      held <= rd_data;
    end
    if (out_load) begin
      out_kind <= load_kind;
      out_slot <= load_slot;
      out_last <= load_last;
    end
  end

  assign result_kind = out_kind;
  assign out_src     = out_slot.src;
  assign out_dest    = out_slot.dst;
  assign out_handle  = out_slot.handle;
  assign out_length  = out_slot.length;
  assign last_of_run = out_last;

  // Checks on the walk and the ring bookkeeping.
  `DSFB_ASSERT_IMP(a_occ_bound, 1'b1, occupancy <= DEPTH_C, "occupancy above depth")
  `DSFB_ASSERT_IMP(a_keep_behind, state == ST_SCAN, keep <= rd_cnt, "compaction overtook walk")
  `DSFB_ASSERT_IMP(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr, "slot read and written")
  `DSFB_ASSERT_NXT(a_start_walk, in_valid && in_ready, state == ST_SCAN, "walk did not start")

endmodule

// File: tb/dsfb_checker.sv
// Checker that predicts and compares the frame buffer's result items.
module dsfb_checker
  import dsfb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  src_addr,
  input  logic [7:0]  dest_addr,
  input  logic [15:0] frame_handle,
  input  logic [11:0] payload_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  result_kind,
  input  logic [7:0]  out_src,
  input  logic [7:0]  out_dest,
  input  logic [15:0] out_handle,
  input  logic [11:0] out_length,
  input  logic        last_of_run,
  output int          mismatch_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result item as the block should present it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] handle;
    logic [11:0] length;
    logic        last;
  } frame_result_t;

  // Descriptors held by the buffer, oldest at the front.
  slot_t         held_frames[$];
  frame_result_t expected_results[$];
  frame_result_t oldest;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  // Compare one field, with X or Z counted as a mismatch.
  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Work out the results of one accepted item and update the held descriptors.
  function automatic void predict_frame_results(logic req, logic [7:0] src, logic [7:0] dst,
                                                logic [15:0] handle, logic [11:0] length);
    slot_t         kept[$];
    frame_result_t res;
    bit            hit;
    hit = 1'b0;
    if (req == REQ_STORE) begin
      foreach (held_frames[i]) begin
        if (held_frames[i].src == src && held_frames[i].dst == dst) begin
          hit = 1'b1;
        end
      end
      res = '{KIND_DUPLICATE, src, dst, handle, length, 1'b1};
      if (!hit) begin
        // A full buffer gives up its oldest descriptor to make room.
        if (held_frames.size() >= DEPTH) begin
          void'(held_frames.pop_front());
        end
        held_frames.push_back('{src, dst, handle, length});
        res.kind = KIND_STORED;
      end
      expected_results.push_back(res);
    end else begin
      // Matching descriptors leave oldest first; the rest keep their order.
      foreach (held_frames[i]) begin
        if (held_frames[i].dst == dst) begin
          res = '{KIND_DELIVERED, held_frames[i].src, held_frames[i].dst,
                  held_frames[i].handle, held_frames[i].length, 1'b0};
          expected_results.push_back(res);
          hit = 1'b1;
        end else begin
          kept.push_back(held_frames[i]);
        end
      end
      held_frames = kept;
      if (hit) begin
        expected_results[$].last = 1'b1;
      end else begin
        expected_results.push_back('{KIND_NONE, 8'd0, dst, 16'd0, 12'd0, 1'b1});
      end
    end
  endfunction

  // Inputs are predicted before outputs are compared; a result can never
  // belong to an item accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      held_frames.delete();
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_frame_results(req_type, src_addr, dest_addr, frame_handle, payload_length);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with none expected: result_kind %0d", result_kind);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("result_kind", oldest.kind, result_kind);
          check_field("out_src", oldest.src, out_src);
          check_field("out_dest", oldest.dst, out_dest);
          check_field("out_handle", oldest.handle, out_handle);
          check_field("out_length", oldest.length, out_length);
          check_field("last_of_run", oldest.last, last_of_run);
        end
      end
    end
    results_pending <= expected_results.size();
  end

endmodule

// File: tb/tb_top.sv
// Stimulus, clocking and verdict for the deduplicating frame buffer.
module tb_top
  import dsfb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS            = DEPTH_DEF;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 3 * (SLOTS + 3);
  localparam int ITEMS_PER_PHASE  = 160;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        req_type       = REQ_STORE;
  logic [7:0]  src_addr       = 8'd0;
  logic [7:0]  dest_addr      = 8'd0;
  logic [15:0] frame_handle   = 16'd0;
  logic [11:0] payload_length = 12'd0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  out_src;
  logic [7:0]  out_dest;
  logic [15:0] out_handle;
  logic [11:0] out_length;
  logic        last_of_run;

  int mismatch_count;
  int results_pending;
  int quiet_cycles  = 0;
  int in_idle_pct   = 24;
  int out_idle_pct  = 64;

  always #5 clk = ~clk;

  dedup_store_forward_frame_buffer_core #(
    .DEPTH(SLOTS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .src_addr      (src_addr),
    .dest_addr     (dest_addr),
    .frame_handle  (frame_handle),
    .payload_length(payload_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .out_src       (out_src),
    .out_dest      (out_dest),
    .out_handle    (out_handle),
    .out_length    (out_length),
    .last_of_run   (last_of_run)
  );

  dsfb_checker #(
    .DEPTH(SLOTS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .src_addr       (src_addr),
    .dest_addr      (dest_addr),
    .frame_handle   (frame_handle),
    .payload_length (payload_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .out_src        (out_src),
    .out_dest       (out_dest),
    .out_handle     (out_handle),
    .out_length     (out_length),
    .last_of_run    (last_of_run),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Watchdog: too long without any item moving ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item after a random gap and hold it until it is accepted.
  task automatic send_item(logic req, logic [7:0] src, logic [7:0] dst,
                           logic [15:0] handle, logic [11:0] length);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= req;
    src_addr       <= src;
    dest_addr      <= dst;
    frame_handle   <= handle;
    payload_length <= length;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly traffic among a few nodes, so that duplicates, multi-frame
  // deliveries and a full buffer are common; the rest is arbitrary addresses.
  task automatic run_traffic(int count, int in_pct, int out_pct);
    logic [7:0] node_pool[6];
    logic [7:0] source_pool[3];
    logic [7:0] src;
    logic [7:0] dst;
    bit         noise;
    bit         fetch;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    foreach (node_pool[i]) node_pool[i] = 8'($urandom);
    foreach (source_pool[i]) source_pool[i] = 8'($urandom);
    for (int n = 0; n < count; n++) begin
      noise = ($urandom_range(0, 9) == 0);
      fetch = ($urandom_range(0, 99) < 30);
      src   = noise ? 8'($urandom) : source_pool[$urandom_range(0, 2)];
      dst   = noise ? 8'($urandom) : node_pool[$urandom_range(0, 5)];
      send_item(fetch ? REQ_FETCH : REQ_STORE, src, dst, 16'($urandom),
                12'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: request on an empty buffer, with junk in the ignored fields.
    send_item(REQ_FETCH, 8'hFF, 8'h00, 16'hFFFF, 12'hFFF);
    // Field extremes and a duplicate.
    send_item(REQ_STORE, 8'h00, 8'h00, 16'h0000, 12'h000);
    send_item(REQ_STORE, 8'hFF, 8'hFF, 16'hFFFF, 12'hFFF);
    send_item(REQ_STORE, 8'h00, 8'h00, 16'h1234, 12'h900);
    send_item(REQ_STORE, 8'hFF, 8'h00, 16'hA5A5, 12'd2304);
    // Two frames for one node, then nothing left for it.
    send_item(REQ_FETCH, 8'h00, 8'h00, 16'h0000, 12'h000);
    send_item(REQ_FETCH, 8'h5A, 8'h00, 16'h5A5A, 12'h5A5);
    // Fill the buffer, overflow it once, then drain all slots in one request.
    for (int i = 0; i < SLOTS; i++) begin
      send_item(REQ_STORE, 8'(i), 8'h5A, 16'($urandom), 12'($urandom_range(0, 4095)));
    end
    send_item(REQ_FETCH, 8'h00, 8'h5A, 16'h0000, 12'h000);
    // The overflow dropped the oldest descriptor.
    send_item(REQ_FETCH, 8'h00, 8'hFF, 16'h0000, 12'h000);

    run_traffic(ITEMS_PER_PHASE, 24, 64);
    run_traffic(ITEMS_PER_PHASE, 64, 24);
    run_traffic(ITEMS_PER_PHASE, 0, 0);
    in_valid <= 1'b0;

    // Drain the outstanding results, then watch for stray ones.
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dsfb_pkg.sv
rtl/dsfb_slot_ram.sv
rtl/dedup_store_forward_frame_buffer_core.sv
tb/dsfb_checker.sv
tb/tb_top.sv
